@@ hdl/utf8_to_utf32_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder assertion macros
// Shared concurrent-assertion forms, clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_DECODER_ASSERT_SVH

// same-cycle implication
`define UTF8DEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UTF8DEC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/utf8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Types and byte-range constants for the strict UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

    localparam int CP_W = 21;

    // result status codes
    typedef enum logic [1:0] {
        STAT_CHAR          = 2'd0,
        STAT_MALFORMED     = 2'd1,
        STAT_TRUNCATED     = 2'd2,
        STAT_END_AFTER_ERR = 2'd3
    } status_t;

    // byte ranges
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD_MIN    = 8'hC2;
    localparam logic [7:0] LEAD_MAX    = 8'hF4;
    localparam logic [7:0] LEAD_3BYTE  = 8'hE0;
    localparam logic [7:0] LEAD_4BYTE  = 8'hF0;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;

    // leads with a narrowed second-byte range
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] E0_LO       = 8'hA0;
    localparam logic [7:0] ED_HI       = 8'h9F;
    localparam logic [7:0] F0_LO       = 8'h90;
    localparam logic [7:0] F4_HI       = 8'h8F;

    typedef struct packed {
        logic              valid;
        logic [CP_W-1:0]   code_point;
        status_t           status;
        logic              last;
    } result_t;

endpackage

@@ hdl/utf8dec_step.sv @@
// ----------------------------------------------------------------------------
// utf8dec_step
// Decoder state and the per-byte legality check and shift-merge. The state
// moves on when the byte held in the input register advances.
// ----------------------------------------------------------------------------
`include "utf8_to_utf32_decoder_assert.svh"

module utf8dec_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_string,
    output utf8dec_pkg::result_t result
);
    import utf8dec_pkg::*;

    logic [1:0]      trail_remaining_reg, trail_remaining_next;
    logic [CP_W-1:0] accumulated_value_reg, accumulated_value_next;
    logic [7:0]      lead_byte_reg, lead_byte_next;
    logic            second_byte_pending_reg, second_byte_pending_next;
    logic            discarding_reg, discarding_next;

    logic [7:0]      cont_lo;
    logic [7:0]      cont_hi;
    logic            cont_ok;
    logic [1:0]      trail_dec;
    logic [CP_W-1:0] acc_merged;

    // continuation range, narrowed on the first trail byte after some leads
    always_comb begin
        cont_lo = CONT_LO;
        cont_hi = CONT_HI;
        if (second_byte_pending_reg) begin
            unique case (lead_byte_reg)
                LEAD_E0: cont_lo = E0_LO;
                LEAD_ED: cont_hi = ED_HI;
                LEAD_F0: cont_lo = F0_LO;
                LEAD_F4: cont_hi = F4_HI;
                default: ;
            endcase
        end
    end

    assign cont_ok    = (in_byte >= cont_lo) && (in_byte <= cont_hi);
    assign trail_dec  = trail_remaining_reg - 2'd1;
    assign acc_merged = {accumulated_value_reg[CP_W-7:0], in_byte[5:0]};

    always_comb begin
        trail_remaining_next     = trail_remaining_reg;
        accumulated_value_next   = accumulated_value_reg;
        lead_byte_next           = lead_byte_reg;
        second_byte_pending_next = second_byte_pending_reg;
        discarding_next          = discarding_reg;
        result.valid             = 1'b0;
        result.code_point        = '0;
        result.status            = STAT_CHAR;
        result.last              = end_of_string;

        if (discarding_reg) begin
            if (end_of_string) begin
                discarding_next = 1'b0;
                result.valid    = 1'b1;
                result.status   = STAT_END_AFTER_ERR;
            end
        end else if (trail_remaining_reg == 2'd0) begin
            if (in_byte < ASCII_LIMIT) begin
                trail_remaining_next     = 2'd0;
                accumulated_value_next   = '0;
                lead_byte_next           = '0;
                second_byte_pending_next = 1'b0;
                result.valid             = 1'b1;
                result.code_point        = {13'd0, in_byte};
            end else if (in_byte < LEAD_MIN || in_byte > LEAD_MAX) begin
                accumulated_value_next   = '0;
                lead_byte_next           = '0;
                second_byte_pending_next = 1'b0;
                discarding_next          = !end_of_string;
                result.valid             = 1'b1;
                result.status            = STAT_MALFORMED;
            end else if (end_of_string) begin
                // lead byte with nothing after it
                accumulated_value_next   = '0;
                lead_byte_next           = '0;
                second_byte_pending_next = 1'b0;
                result.valid             = 1'b1;
                result.status            = STAT_TRUNCATED;
            end else begin
                lead_byte_next           = in_byte;
                second_byte_pending_next = 1'b1;
                if (in_byte < LEAD_3BYTE) begin
                    trail_remaining_next   = 2'd1;
                    accumulated_value_next = {16'd0, in_byte[4:0]};
                end else if (in_byte < LEAD_4BYTE) begin
                    trail_remaining_next   = 2'd2;
                    accumulated_value_next = {17'd0, in_byte[3:0]};
                end else begin
                    trail_remaining_next   = 2'd3;
                    accumulated_value_next = {18'd0, in_byte[2:0]};
                end
            end
        end else if (!cont_ok) begin
            trail_remaining_next     = 2'd0;
            accumulated_value_next   = '0;
            lead_byte_next           = '0;
            second_byte_pending_next = 1'b0;
            discarding_next          = !end_of_string;
            result.valid             = 1'b1;
            result.status            = STAT_MALFORMED;
        end else if (trail_dec == 2'd0) begin
            trail_remaining_next     = 2'd0;
            accumulated_value_next   = '0;
            lead_byte_next           = '0;
            second_byte_pending_next = 1'b0;
            result.valid             = 1'b1;
            result.code_point        = acc_merged;
        end else if (end_of_string) begin
            trail_remaining_next     = 2'd0;
            accumulated_value_next   = '0;
            lead_byte_next           = '0;
            second_byte_pending_next = 1'b0;
            result.valid             = 1'b1;
            result.status            = STAT_TRUNCATED;
        end else begin
            trail_remaining_next     = trail_dec;
            accumulated_value_next   = acc_merged;
            second_byte_pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trail_remaining_reg     <= '0;
            accumulated_value_reg   <= '0;
            lead_byte_reg           <= '0;
            second_byte_pending_reg <= 1'b0;
            discarding_reg          <= 1'b0;
        end else if (advance) begin
            trail_remaining_reg     <= trail_remaining_next;
            accumulated_value_reg   <= accumulated_value_next;
            lead_byte_reg           <= lead_byte_next;
            second_byte_pending_reg <= second_byte_pending_next;
            discarding_reg          <= discarding_next;
        end
    end

    `UTF8DEC_ASSERT_IMP(a_discard_no_open_seq, discarding_reg, trail_remaining_reg == 2'd0, "open sequence while discarding")
    `UTF8DEC_ASSERT_IMP(a_second_pending_open, second_byte_pending_reg, trail_remaining_reg != 2'd0, "second byte pending with no open sequence")
    `UTF8DEC_ASSERT_IMP(a_noncharacter_zero_cp, result.valid && result.status != STAT_CHAR, result.code_point == '0, "code point set on a status result")
    `UTF8DEC_ASSERT_NXT(a_end_clears_state, advance && end_of_string, trail_remaining_reg == 2'd0 && !discarding_reg && !second_byte_pending_reg, "state not cleared after end of string")

endmodule

@@ hdl/utf8_to_utf32_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder
// Strict UTF-8 byte stream to UTF-32 code point decoder.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on s_ and gives at most one result per byte on m_.
// A byte is captured in an input register, checked and merged into the open
// sequence in one pass, and its result lands in the output register, so a
// result is offered on m_ after passing through both registers. Sustained
// rate is one byte per clock as long as m_ready stays high; the input register
// advances whenever the output register is free or being drained, so s_ready
// follows m_ready combinationally. Status 0 carries a code point; 1 flags the
// first malformed byte, 2 a sequence cut off by the end-marked byte, 3 the end
// of a string after an error. m_last marks the result of the end-marked byte.
module utf8_to_utf32_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_in_byte,
    input  logic                          s_end_of_string,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [utf8dec_pkg::CP_W-1:0]  m_code_point,
    output logic [1:0]                    m_status,
    output logic                          m_last
);
    import utf8dec_pkg::*;

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_eos_reg;

    logic            out_valid_reg;
    logic [CP_W-1:0] code_point_reg;
    status_t         status_reg;
    logic            last_reg;

    logic            out_free;
    logic            advance;
    result_t         result;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_eos_reg  <= s_end_of_string;
        end
    end

    utf8dec_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .in_byte       (in_byte_reg),
        .end_of_string (in_eos_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            code_point_reg <= result.code_point;
            status_reg     <= result.status;
            last_reg       <= result.last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_code_point = code_point_reg;
    assign m_status     = status_reg;
    assign m_last       = last_reg;

endmodule
